/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds after reset
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// property checked also during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

/* rtl/core/gte_pkg.sv */
// shared types and constants of the graph traversal engine
// no dependencies
`default_nettype none
package gte_pkg;
  localparam int unsigned GteMaxVertices = 32;
  localparam int unsigned GteEdgeSlots   = 128;
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_BFS   = 2'd1;
  localparam logic [1:0] CMD_DFS   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;
  localparam logic [1:0] KIND_VISIT = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_RANGE = 2'd3;
  typedef logic [1:0] kind_t;
endpackage
`default_nettype wire

/* rtl/core/graph_traversal_engine_core.sv */
// Graph traversal engine: an undirected graph in adjacency lists with breadth-first and
// depth-first walks. Every command answers with one done, pool-full or range beat
// carrying out_last; a walk first sends one beat per newly visited vertex, though a
// breadth-first walk sends none for its start vertex. An add edge writes both of its
// list entries (S_ADD1, S_ADD2) before its beat. A breadth-first walk pops each queued
// vertex and reads its list entries one at a time; a depth-first walk reads the top
// stack link, checks its target and pushes each new vertex. Each visit beat waits while
// out_ready is low. The edge pool has a single read port. A write of vertex_count clears
// the graph. No item is taken while a command runs; the next one may enter while the final beat waits.
// Depends on gte_pkg.
`default_nettype none
module graph_traversal_engine_core
  import gte_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = GteMaxVertices,
  parameter int unsigned EDGE_SLOTS   = GteEdgeSlots
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [4:0]  in_first_vertex,
  input  wire logic [4:0]  in_second_vertex,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_vertex_out,
  output logic [1:0]       out_kind,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int LW = $clog2(EDGE_SLOTS + 1);   // link: index+1, 0 = end
  localparam int EW = $clog2(EDGE_SLOTS);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int OW = $clog2(MAX_VERTICES + 2);

  localparam logic [3:0] S_IDLE = 4'd0, S_ADD1 = 4'd1, S_ADD2 = 4'd2,
    S_FIN = 4'd3, S_BPOP = 4'd4, S_BRD = 4'd5, S_BCHK = 4'd6,
    S_DTOP = 4'd7, S_DRD = 4'd8, S_DCHK = 4'd9, S_OUT = 4'd10, S_DPUSH = 4'd11;

  logic [3:0] st_r;
  logic [5:0] vcount_r;
  logic [LW-1:0] head_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis_r;
  logic [LW-1:0] used_r;
  logic [4:0] tgt_mem [EDGE_SLOTS];
  logic [LW-1:0] lnk_mem [EDGE_SLOTS];
  logic [LW-1:0] wrk_mem [MAX_VERTICES];
  logic [4:0] rd_tgt_r;
  logic [LW-1:0] rd_lnk_r, link_r;
  logic [SW-1:0] qh_r, qt_r;
  logic [OW-1:0] nout_r;
  logic [VW-1:0] a_r, b_r, cur_r;
  logic [4:0] ov_r;
  kind_t okind_r, fin_kind_r;
  logic olast_r, oval_r;
  logic [3:0] ret_r;
  logic [6:0] ecount;
  logic cfg_wr;

  assign ecount = (vcount_r > 6'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : {1'b0, vcount_r};
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {26'd0, vcount_r} : 32'd0;
  assign in_ready = (st_r == S_IDLE) && !cfg_wr;
  assign out_valid = oval_r;
  assign out_vertex_out = ov_r;
  assign out_kind = okind_r;
  assign out_last = olast_r;

  wire acc = in_valid & in_ready;
  wire [EW-1:0] lidx = EW'(link_r - LW'(1));
  wire link_ok = (link_r != '0) && ({1'b0, link_r} <= (LW+1)'(EDGE_SLOTS));
  wire tgt_ok = (32'(rd_tgt_r) < MAX_VERTICES);
  wire [VW-1:0] tv = VW'(rd_tgt_r);
  wire tgt_new = tgt_ok && !vis_r[tv];

  // edge pool, clocked reads and writes
  always_ff @(posedge clk) begin
    rd_tgt_r <= tgt_mem[lidx];
    rd_lnk_r <= lnk_mem[lidx];
    if (st_r == S_ADD1) begin
      tgt_mem[used_r[EW-1:0]] <= 5'(b_r);
      lnk_mem[used_r[EW-1:0]] <= head_r[a_r];
    end
    if (st_r == S_ADD2) begin
      tgt_mem[used_r[EW-1:0]] <= 5'(a_r);
      lnk_mem[used_r[EW-1:0]] <= head_r[b_r];
    end
  end

  logic [SW-1:0] wr_idx;
  logic [LW-1:0] wr_dat;
  logic wr_en;
  always_comb begin
    wr_en = 1'b0; wr_idx = qt_r; wr_dat = '0;
    if (st_r == S_IDLE) begin
      // first queue or stack entry of a walk
      wr_en = acc; wr_idx = '0;
      wr_dat = (in_command == CMD_BFS) ? LW'(in_first_vertex) :
               head_r[VW'(in_first_vertex)];
    end else if (st_r == S_BCHK && tgt_new && qt_r < SW'(MAX_VERTICES)) begin
      wr_en = 1'b1; wr_dat = LW'(tv);
    end else if (st_r == S_DCHK) begin
      wr_en = 1'b1; wr_idx = qt_r - SW'(1); wr_dat = rd_lnk_r;
    end else if (st_r == S_DPUSH) begin
      wr_en = 1'b1; wr_dat = head_r[tv];
    end
  end
  logic [LW-1:0] wrk_rd;
  assign wrk_rd = wrk_mem[VW'(st_r == S_BPOP ? qh_r : qt_r - SW'(1))];

  always_ff @(posedge clk) begin
    if (wr_en) wrk_mem[VW'(wr_idx)] <= wr_dat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vcount_r <= 6'd32; used_r <= '0; vis_r <= '0;
      oval_r <= 1'b0; nout_r <= '0; qh_r <= '0; qt_r <= '0; ret_r <= S_IDLE;
      for (int i = 0; i < MAX_VERTICES; i++) head_r[i] <= '0;
    end else begin
      if (oval_r && out_ready) oval_r <= 1'b0;
      if (cfg_wr && cfg_paddr[2] == 1'b0) begin
        vcount_r <= cfg_pwdata[5:0];
        used_r <= '0; vis_r <= '0;
        for (int i = 0; i < MAX_VERTICES; i++) head_r[i] <= '0;
      end
      unique case (st_r)
        S_IDLE: if (acc) begin
          a_r <= VW'(in_first_vertex); b_r <= VW'(in_second_vertex);
          cur_r <= VW'(in_first_vertex); nout_r <= '0; qh_r <= '0; qt_r <= '0;
          fin_kind_r <= KIND_DONE; st_r <= S_FIN;
          unique case (in_command)
            CMD_ADD: begin
              if ({2'b0, in_first_vertex} >= ecount || {2'b0, in_second_vertex} >= ecount)
                fin_kind_r <= KIND_RANGE;
              else if (32'(used_r) + 2 > EDGE_SLOTS) fin_kind_r <= KIND_FULL;
              else st_r <= S_ADD1;
            end
            CMD_BFS, CMD_DFS: begin
              if ({2'b0, in_first_vertex} >= ecount) fin_kind_r <= KIND_RANGE;
              else begin
                vis_r[VW'(in_first_vertex)] <= 1'b1;
                if (in_command == CMD_BFS) begin
                  qt_r <= SW'(1); st_r <= S_BPOP;
                end else begin
                  qt_r <= SW'(1); nout_r <= OW'(1);
                  ret_r <= S_DTOP; st_r <= S_OUT;
                end
              end
            end
            default: begin
              used_r <= '0; vis_r <= '0;
              for (int i = 0; i < MAX_VERTICES; i++) head_r[i] <= '0;
            end
          endcase
        end
        S_ADD1: begin
          head_r[a_r] <= used_r + LW'(1); used_r <= used_r + LW'(1); st_r <= S_ADD2;
        end
        S_ADD2: begin
          head_r[b_r] <= used_r + LW'(1); used_r <= used_r + LW'(1); st_r <= S_FIN;
        end
        S_FIN: if (!oval_r) begin
          oval_r <= 1'b1; ov_r <= '0; okind_r <= fin_kind_r; olast_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_OUT: if (!oval_r) begin
          oval_r <= 1'b1; ov_r <= 5'(cur_r); okind_r <= KIND_VISIT; olast_r <= 1'b0;
          st_r <= ret_r;
        end
        // breadth-first: pop queue entry, then walk its list
        S_BPOP: begin
          if (qh_r == qt_r) begin
            fin_kind_r <= KIND_DONE; st_r <= S_FIN;
          end else begin
            link_r <= head_r[VW'(wrk_rd)]; qh_r <= qh_r + SW'(1); st_r <= S_BRD;
          end
        end
        S_BRD: st_r <= link_ok ? S_BCHK : S_BPOP;
        S_BCHK: begin
          link_r <= rd_lnk_r; st_r <= S_BRD;
          if (tgt_new) begin
            vis_r[tv] <= 1'b1;
            if (qt_r < SW'(MAX_VERTICES)) qt_r <= qt_r + SW'(1);
            if (nout_r < OW'(MAX_VERTICES)) begin
              nout_r <= nout_r + OW'(1); cur_r <= tv;
              ret_r <= S_BRD; st_r <= S_OUT;
            end
          end
        end
        // depth-first: stack of next links, top entry read each round
        S_DTOP: begin
          if (qt_r == '0) begin
            fin_kind_r <= KIND_DONE; st_r <= S_FIN;
          end else begin
            link_r <= wrk_rd; st_r <= S_DRD;
          end
        end
        S_DRD: begin
          if (!link_ok) begin
            qt_r <= qt_r - SW'(1); st_r <= S_DTOP;
          end else st_r <= S_DCHK;
        end
        // top entry advances to its next link here
        S_DCHK: begin
          st_r <= S_DTOP;
          if (tgt_new) begin
            vis_r[tv] <= 1'b1;
            if (qt_r < SW'(MAX_VERTICES)) st_r <= S_DPUSH;
            else if (nout_r < OW'(MAX_VERTICES)) begin
              nout_r <= nout_r + OW'(1); cur_r <= tv;
              ret_r <= S_DTOP; st_r <= S_OUT;
            end
          end
        end
        S_DPUSH: begin
          qt_r <= qt_r + SW'(1); st_r <= S_DTOP;
          if (nout_r < OW'(MAX_VERTICES)) begin
            nout_r <= nout_r + OW'(1); cur_r <= tv;
            ret_r <= S_DTOP; st_r <= S_OUT;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/gte_checker.sv */
// port-level checks for the graph traversal engine core
// depends on assert_macros.svh and gte_pkg; bound to graph_traversal_engine_core
`default_nettype none
`include "assert_macros.svh"
module gte_checker
  import gte_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] out_vertex_out,
  input wire logic [1:0] out_kind,
  input wire logic       out_last,
  input wire logic       cfg_pready
);
  wire end_beat = out_valid && (out_kind != KIND_VISIT);
  // non-visit beats carry vertex zero and end the command
  `ASSERT_CLK(a_end_beat, clk, rst_n, end_beat |-> (out_vertex_out == 5'd0 && out_last))
  `ASSERT_CLK(a_last_kind, clk, rst_n, (out_valid && out_last) |-> (out_kind != KIND_VISIT))
  // a command keeps the input closed while it runs
  `ASSERT_CLK(a_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_kind)))
  `ASSERT_ALWAYS(a_pready, clk, cfg_pready)
endmodule
bind graph_traversal_engine_core gte_checker u_gte_checker (.*);
`default_nettype wire
